[rtl/sdfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sdfc_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_RADIUS      = 3'd2,
    CFG_FG_COLOR    = 3'd3,
    CFG_PITCH_WORDS = 3'd4
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int CENTER_W = 12;
  localparam int RADIUS_W = 11;
  localparam int COLOR_W  = 24;
  localparam int PITCH_W  = 13;
  localparam int INDEX_W  = 24;
  localparam int PIXEL_W  = 32;
  localparam int CHAN_W   = 8;

  // Coverage is expressed in thousandths.
  localparam int COV_W = 10;
  localparam logic [COV_W-1:0] COV_FULL = 10'd1000;
  localparam int COV_HALF     = 500;
  localparam int RADIUS_SCALE = 1000;

  // 1000000 = 15625 * 64, applied as a multiply and a shift.
  localparam int SCALE_K_W     = 14;
  localparam int SCALE_K       = 15625;
  localparam int SCALE_SHIFT   = 6;

  // floor(s / 1000) = (s * RECIP_M) >> RECIP_SHIFT, exact for s below 2^18.
  localparam int BLEND_W     = 18;
  localparam int RECIP_W     = 18;
  localparam int RECIP_M     = 134218;
  localparam int RECIP_SHIFT = 27;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

endpackage

`default_nettype wire

[rtl/sdfc_isqrt_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring integer square root, one root bit per pipeline stage.
module sdfc_isqrt_pipe #(
  parameter int RAD_W  = 46,
  parameter int SIDE_W = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [RAD_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [RAD_W/2-1:0]        root_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int TRY_W  = REM_W + 2;

  logic              valid_q [ROOT_W];
  logic              ready   [ROOT_W];
  logic [RAD_W-1:0]  rad_q   [ROOT_W];
  logic [REM_W-1:0]  rem_q   [ROOT_W];
  logic [ROOT_W-1:0] root_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              prev_valid;
    logic [RAD_W-1:0]  prev_rad;
    logic [REM_W-1:0]  prev_rem;
    logic [ROOT_W-1:0] prev_root;
    logic [SIDE_W-1:0] prev_side;
    logic              next_ready;
    logic [TRY_W-1:0]  cat;
    logic [TRY_W-1:0]  sub;
    logic              take;

    if (k == 0) begin : g_first
      assign prev_valid = in_valid_i;
      assign prev_rad   = rad_i;
      assign prev_rem   = '0;
      assign prev_root  = '0;
      assign prev_side  = side_i;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_rad   = rad_q[k-1];
      assign prev_rem   = rem_q[k-1];
      assign prev_root  = root_q[k-1];
      assign prev_side  = side_q[k-1];
    end

    if (k == ROOT_W - 1) begin : g_last
      assign next_ready = out_ready_i;
    end else begin : g_mid
      assign next_ready = ready[k+1];
    end

    assign ready[k] = !valid_q[k] || next_ready;

    // Bring down the next two radicand bits and try subtracting 4*root+1.
    assign cat  = {prev_rem, prev_rad[RAD_W-1 -: 2]};
    assign sub  = TRY_W'({prev_root, 2'b01});
    assign take = (cat >= sub);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k] && prev_valid) begin
        rad_q[k]  <= prev_rad << 2;
        rem_q[k]  <= take ? REM_W'(cat - sub) : REM_W'(cat);
        root_q[k] <= {prev_root[ROOT_W-2:0], take};
        side_q[k] <= prev_side;
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[ROOT_W-1];
  assign root_o      = root_q[ROOT_W-1];
  assign side_o      = side_q[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/sdf_circle_pixel_blend_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: stages 1 to 5, then the square root pipeline, which resolves one distance bit per stage,
// then stages 6 to 10.
// Throughput: one pixel per clock; every stage carries its own valid bit and holds only
// when it is full and the stage after it cannot take its contents.
// Reset: asynchronous, active low; it clears all valid bits and all configuration registers.
module sdf_circle_pixel_blend_unit
  import sdfc_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  // Configuration write port, no read-back.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,

  // Pixel requests in.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // From bit 0 up: px, py, background, zero fill.
  input  wire logic [((2*COORD_BITS+PIXEL_W+7)/8)*8-1:0] s_axis_tdata,

  // Blended pixels out.
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // From bit 0 up: pixel_index, pixel_value.
  output logic [((INDEX_W+PIXEL_W+7)/8)*8-1:0] m_axis_tdata,
  // Bit 0: write_pixel.
  output logic                       m_axis_tuser
);

  localparam int CB      = COORD_BITS;
  localparam int S_W     = ((2*CB+PIXEL_W+7)/8)*8;
  localparam int M_W     = ((INDEX_W+PIXEL_W+7)/8)*8;
  localparam int YP_W    = CB + PITCH_W;
  localparam int IXS_W   = YP_W + 1;
  localparam int SQ_W    = 2*CB + 1;
  localparam int LO_W    = CB + 1 + SCALE_K_W;
  localparam int HI_W    = CB + SCALE_K_W;
  localparam int RAD_W   = SQ_W + SCALE_SHIFT + SCALE_K_W + 1;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int RK_W    = RADIUS_W + 10;
  localparam int D_W     = ((ROOT_W > RK_W) ? ROOT_W : RK_W) + 1;
  localparam int PROD_W  = BLEND_W + RECIP_W;

  // Everything that rides alongside the distance computation.
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] bg;
  } side_t;

  //--------------------------------------------------------------------------
  // Configuration registers. The user must write only while the pipeline is empty; the block does not enforce it.
  //--------------------------------------------------------------------------
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [RADIUS_W-1:0] radius_q;
  logic [COLOR_W-1:0]  fg_color_q;
  logic [PITCH_W-1:0]  pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      radius_q   <= '0;
      fg_color_q <= '0;
      pitch_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:    center_x_q <= cfg_wdata_i[CENTER_W-1:0];
        CFG_CENTER_Y:    center_y_q <= cfg_wdata_i[CENTER_W-1:0];
        CFG_RADIUS:      radius_q   <= cfg_wdata_i[RADIUS_W-1:0];
        CFG_FG_COLOR:    fg_color_q <= cfg_wdata_i[COLOR_W-1:0];
        CFG_PITCH_WORDS: pitch_q    <= cfg_wdata_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Ready chain. A stage takes new data when it is empty or when its
  // contents move on in the same cycle, so bubbles collapse and the input
  // keeps flowing while a finished result waits at the output register.
  //--------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic r1, r2, r3, r4, r5, r6, r7, r8, r9, r10;
  logic sq_in_ready, sq_out_valid;

  assign r10 = !v10_q || m_axis_tready;
  assign r9  = !v9_q  || r10;
  assign r8  = !v8_q  || r9;
  assign r7  = !v7_q  || r8;
  assign r6  = !v6_q  || r7;
  assign r5  = !v5_q  || sq_in_ready;
  assign r4  = !v4_q  || r5;
  assign r3  = !v3_q  || r4;
  assign r2  = !v2_q  || r3;
  assign r1  = !v1_q  || r2;

  assign s_axis_tready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      if (r1)  v1_q  <= s_axis_tvalid;
      if (r2)  v2_q  <= v1_q;
      if (r3)  v3_q  <= v2_q;
      if (r4)  v4_q  <= v3_q;
      if (r5)  v5_q  <= v4_q;
      if (r6)  v6_q  <= sq_out_valid;
      if (r7)  v7_q  <= v6_q;
      if (r8)  v8_q  <= v7_q;
      if (r9)  v9_q  <= v8_q;
      if (r10) v10_q <= v9_q;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 1: absolute offsets from the center, and the row start product.
  //--------------------------------------------------------------------------
  logic [CB-1:0]      in_x, in_y, cx, cy;
  logic [CB-1:0]      adx_d, ady_d;
  logic [CB-1:0]      adx_q, ady_q, x1_q;
  logic [YP_W-1:0]    ypitch_q;
  logic [COLOR_W-1:0] bg1_q;

  assign in_x  = s_axis_tdata[CB-1:0];
  assign in_y  = s_axis_tdata[2*CB-1:CB];
  assign cx    = CB'(center_x_q);
  assign cy    = CB'(center_y_q);
  assign adx_d = (in_x >= cx) ? (in_x - cx) : (cx - in_x);
  assign ady_d = (in_y >= cy) ? (in_y - cy) : (cy - in_y);

  always_ff @(posedge clk_i) begin
    if (r1 && s_axis_tvalid) begin
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      x1_q     <= in_x;
      ypitch_q <= YP_W'(in_y) * YP_W'(pitch_q);
      // The background alpha byte plays no part.
      bg1_q    <= s_axis_tdata[2*CB +: COLOR_W];
    end
  end

  //--------------------------------------------------------------------------
  // Stage 2: squared offsets and the frame buffer word index.
  //--------------------------------------------------------------------------
  logic [2*CB-1:0]    sqx_q, sqy_q;
  logic [INDEX_W-1:0] idx2_q;
  logic [COLOR_W-1:0] bg2_q;
  logic [IXS_W-1:0]   idx_sum;

  assign idx_sum = IXS_W'(ypitch_q) + IXS_W'(x1_q);

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      sqx_q  <= (2*CB)'(adx_q) * (2*CB)'(adx_q);
      sqy_q  <= (2*CB)'(ady_q) * (2*CB)'(ady_q);
      idx2_q <= INDEX_W'(idx_sum);
      bg2_q  <= bg1_q;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 3: squared distance in pixels.
  //--------------------------------------------------------------------------
  logic [SQ_W-1:0] sq3_q;
  side_t           side3_q;

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      sq3_q       <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
      side3_q.idx <= idx2_q;
      side3_q.bg  <= bg2_q;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 4: scale by 15625 in two halves to keep each multiplier narrow.
  //--------------------------------------------------------------------------
  logic [LO_W-1:0] plo_q;
  logic [HI_W-1:0] phi_q;
  side_t           side4_q;

  always_ff @(posedge clk_i) begin
    if (r4 && v3_q) begin
      plo_q   <= LO_W'(sq3_q[CB:0]) * LO_W'(SCALE_K);
      phi_q   <= HI_W'(sq3_q[SQ_W-1:CB+1]) * HI_W'(SCALE_K);
      side4_q <= side3_q;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 5: recombine the halves and apply the power of two, which gives
  // the squared distance in millionths of a square pixel.
  //--------------------------------------------------------------------------
  logic [RAD_W-1:0] rad_d, rad5_q;
  side_t            side5_q;

  assign rad_d = ((RAD_W'(phi_q) << (CB + 1)) + RAD_W'(plo_q)) << SCALE_SHIFT;

  always_ff @(posedge clk_i) begin
    if (r5 && v4_q) begin
      rad5_q  <= rad_d;
      side5_q <= side4_q;
    end
  end

  //--------------------------------------------------------------------------
  // Square root pipeline: distance in thousandths of a pixel.
  //--------------------------------------------------------------------------
  logic [ROOT_W-1:0]   dist_mp;
  logic [$bits(side_t)-1:0] sq_side_out;
  side_t               sq_side;

  sdfc_isqrt_pipe #(
    .RAD_W  (RAD_W),
    .SIDE_W ($bits(side_t))
  ) u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .in_ready_o  (sq_in_ready),
    .rad_i       (rad5_q),
    .side_i      (side5_q),
    .out_valid_o (sq_out_valid),
    .out_ready_i (r6),
    .root_o      (dist_mp),
    .side_o      (sq_side_out)
  );

  assign sq_side = side_t'(sq_side_out);

  //--------------------------------------------------------------------------
  // Stage 6: signed distance to the rim, divided by four with truncation
  // toward zero (negative values round up).
  //--------------------------------------------------------------------------
  logic signed [D_W-1:0] dsd, qtr_d, qtr6_q;
  side_t                 side6_q;

  assign dsd   = $signed(D_W'(dist_mp)) - $signed(D_W'(RK_W'(radius_q) * RK_W'(RADIUS_SCALE)));
  assign qtr_d = dsd[D_W-1] ? ((dsd + D_W'(3)) >>> 2) : (dsd >>> 2);

  always_ff @(posedge clk_i) begin
    if (r6 && sq_out_valid) begin
      qtr6_q  <= qtr_d;
      side6_q <= sq_side;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 7: coverage = 500 - quarter, clamped to 0..1000.
  //--------------------------------------------------------------------------
  logic [COV_W-1:0] cov_d, cov7_q;
  side_t            side7_q;
  logic signed [D_W-1:0] cov_full_s;

  assign cov_full_s = D_W'(COV_HALF) - qtr6_q;

  always_comb begin
    if (qtr6_q > $signed(D_W'(COV_HALF))) begin
      cov_d = '0;
    end else if (qtr6_q < -$signed(D_W'(COV_HALF))) begin
      cov_d = COV_FULL;
    end else begin
      cov_d = COV_W'(cov_full_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r7 && v6_q) begin
      cov7_q  <= cov_d;
      side7_q <= side6_q;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 8: weighted channel sums fg*cov + bg*(1000-cov).
  //--------------------------------------------------------------------------
  logic [COV_W-1:0]   icov;
  logic [BLEND_W-1:0] mix_d [3];
  logic [BLEND_W-1:0] mix8_q [3];
  logic [INDEX_W-1:0] idx8_q;
  logic               wr8_q;

  assign icov = COV_FULL - cov7_q;

  for (genvar c = 0; c < 3; c++) begin : g_mix
    assign mix_d[c] = BLEND_W'(fg_color_q[c*CHAN_W +: CHAN_W]) * BLEND_W'(cov7_q)
                    + BLEND_W'(side7_q.bg[c*CHAN_W +: CHAN_W]) * BLEND_W'(icov);
  end

  always_ff @(posedge clk_i) begin
    if (r8 && v7_q) begin
      mix8_q <= mix_d;
      idx8_q <= side7_q.idx;
      wr8_q  <= (cov7_q != '0);
    end
  end

  //--------------------------------------------------------------------------
  // Stage 9: divide by 1000 through a reciprocal multiply.
  //--------------------------------------------------------------------------
  logic [PROD_W-1:0]  prod9_q [3];
  logic [INDEX_W-1:0] idx9_q;
  logic               wr9_q;

  always_ff @(posedge clk_i) begin
    if (r9 && v8_q) begin
      for (int c = 0; c < 3; c++) begin
        prod9_q[c] <= PROD_W'(mix8_q[c]) * PROD_W'(RECIP_M);
      end
      idx9_q <= idx8_q;
      wr9_q  <= wr8_q;
    end
  end

  //--------------------------------------------------------------------------
  // Stage 10: output register.
  //--------------------------------------------------------------------------
  logic [COLOR_W-1:0] rgb_d;
  logic [M_W-1:0]     tdata_q;
  logic               tuser_q;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign rgb_d[c*CHAN_W +: CHAN_W] = prod9_q[c][RECIP_SHIFT +: CHAN_W];
  end

  always_ff @(posedge clk_i) begin
    if (r10 && v9_q) begin
      tdata_q <= M_W'({ALPHA_OPAQUE, rgb_d, idx9_q});
      tuser_q <= wr9_q;
    end
  end

  assign m_axis_tvalid = v10_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  // Input bits above the background colour (its alpha byte and any padding) carry nothing.
  logic unused_pad;
  assign unused_pad = ^{s_axis_tdata[S_W-1:2*CB+COLOR_W]};

endmodule

`default_nettype wire
